[rtl/core/csn_pkg.sv]
// csn_pkg: types, codes and constants shared by the clock sync node modules.
// No dependencies; every other file in rtl/core imports it.
package csn_pkg;

  // beat widths on the stream ports
  localparam int IN_TDATA_W  = 128;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 120;
  localparam int OUT_TUSER_W = 3;

  localparam int ADDR_W  = 32;
  localparam int SEC_W   = 32;
  localparam int US_W    = 20;
  localparam int CLK_W   = 64;
  localparam int PROD_W  = 52;   // seconds times one million
  localparam int QIN_W   = 33;   // seconds plus a carry from the micros
  localparam int Q_W     = 45;   // whole seconds of a 64-bit microsecond count

  localparam int QUEUE_DEPTH_DEF = 2;

  // clock split into seconds and micros, DIV_BITS quotient bits per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_ITERS = CLK_W / DIV_BITS;
  localparam int DCNT_W    = $clog2(DIV_ITERS);

  localparam logic [US_W-1:0]   US_PER_S   = 20'd1000000;
  localparam logic [ADDR_W-1:0] BCAST_ADDR = 32'hFFFF_FFFF;

  localparam logic [3:0] OP_TICK       = 4'd0;
  localparam logic [3:0] OP_HELLO      = 4'd1;
  localparam logic [3:0] OP_SET_MASTER = 4'd2;
  localparam logic [3:0] OP_SET_SLAVE  = 4'd3;
  localparam logic [3:0] OP_SET_TIME   = 4'd4;
  localparam logic [3:0] OP_GET_TIME   = 4'd5;
  localparam logic [3:0] OP_SYNC       = 4'd6;
  localparam logic [3:0] OP_DELAY_REQ  = 4'd7;
  localparam logic [3:0] OP_DELAY_RESP = 4'd8;
  localparam logic [3:0] OP_SEND_SYNC  = 4'd9;

  typedef enum logic [3:0] {
    K_TICK, K_HELLO, K_SET_MASTER, K_SET_SLAVE, K_SET_TIME,
    K_GET_TIME, K_SYNC, K_DELAY_REQ, K_DELAY_RESP, K_SEND_SYNC
  } kind_t;

  typedef enum logic [1:0] {
    ROLE_UNDEF  = 2'd0,
    ROLE_SLAVE  = 2'd1,
    ROLE_MASTER = 2'd2
  } role_t;

  typedef enum logic [2:0] {
    CODE_ACK  = 3'd0,
    CODE_DRQ  = 3'd1,
    CODE_TIME = 3'd2,
    CODE_DRE  = 3'd3,
    CODE_SYN  = 3'd4
  } code_t;

  typedef enum logic [2:0] {
    BS_EXEC, BS_DIFF, BS_SUM, BS_HALF, BS_OFFS, BS_APPLY, BS_DIV
  } bstate_t;

  typedef struct packed {
    logic [3:0]        opcode;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
    logic [7:0]        arg_count;
    logic [SEC_W-1:0]  sec;
    logic [US_W-1:0]   micros;
  } in_item_t;

  // classified command handed from front to back
  typedef struct packed {
    kind_t             kind;
    logic [3:0]        opcode;
    logic [ADDR_W-1:0] reply_dst;
    logic              load;
    logic [PROD_W-1:0] prod;
    logic [US_W-1:0]   micros;
    logic [QIN_W-1:0]  q_in;
    logic [US_W-1:0]   r_in;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
    code_t             code;
    logic [1:0]        arg_count;
    logic [31:0]       arg0;
    logic [US_W-1:0]   arg1;
  } reply_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

endpackage

[rtl/core/csn_fifo.sv]
// csn_fifo: short command queue between the front and back of the node.
// Depends on csn_pkg for the command type and status struct.
module csn_fifo #(
  parameter int DEPTH = csn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  csn_pkg::cmd_t         push_data,
  input  logic                  pop,
  output csn_pkg::cmd_t         head,
  output csn_pkg::fifo_stat_t   stat
);
  import csn_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head           = mem_r[rd_ptr_r];
  assign stat.not_empty = (cnt_r != '0);
  assign stat.full      = (cnt_r == CNT_W'(DEPTH));

endmodule

[rtl/core/csn_front.sv]
// csn_front: takes input beats, filters on address and classifies them,
// holds the node address register. Depends on csn_pkg.
module csn_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  csn_pkg::in_item_t      in_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [31:0]            cfg_data,
  input  csn_pkg::fifo_stat_t    fifo_stat,
  output logic                   push,
  output csn_pkg::cmd_t          push_data,
  output logic [31:0]            node_addr
);
  import csn_pkg::*;

  logic [ADDR_W-1:0] node_addr_r;
  logic              addr_hit;
  logic              keep;
  logic              us_big;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= '0;
    end else if (cfg_valid) begin
      node_addr_r <= cfg_data;
    end
  end

  always_comb begin
    addr_hit = (in_item.dst == node_addr_r) || (in_item.dst == BCAST_ADDR);
    us_big   = (in_item.micros >= US_PER_S);

    push_data.opcode    = in_item.opcode;
    push_data.reply_dst = in_item.src;
    push_data.load      = (in_item.arg_count == 8'd2);
    push_data.prod      = PROD_W'(in_item.sec) * PROD_W'(US_PER_S);
    push_data.micros    = in_item.micros;
    // seconds and micros of a loaded time, micros below two million
    push_data.q_in      = QIN_W'(in_item.sec) + QIN_W'(us_big);
    push_data.r_in      = us_big ? in_item.micros - US_PER_S : in_item.micros;

    keep           = addr_hit;
    push_data.kind = K_HELLO;
    case (in_item.opcode)
      OP_TICK: begin
        keep           = 1'b1;
        push_data.kind = K_TICK;
      end
      OP_SEND_SYNC: begin
        keep           = 1'b1;
        push_data.kind = K_SEND_SYNC;
      end
      OP_HELLO:      push_data.kind = K_HELLO;
      OP_SET_MASTER: push_data.kind = K_SET_MASTER;
      OP_SET_SLAVE:  push_data.kind = K_SET_SLAVE;
      OP_SET_TIME:   push_data.kind = K_SET_TIME;
      OP_GET_TIME:   push_data.kind = K_GET_TIME;
      OP_SYNC:       push_data.kind = K_SYNC;
      OP_DELAY_REQ:  push_data.kind = K_DELAY_REQ;
      OP_DELAY_RESP: push_data.kind = K_DELAY_RESP;
      default:       keep = 1'b0;
    endcase
  end

  // dropped beats are still taken, they just never reach the queue
  assign in_ready  = !fifo_stat.full;
  assign push      = in_valid && in_ready && keep;
  assign cfg_ready = 1'b1;
  assign node_addr = node_addr_r;

endmodule

[rtl/core/csn_back.sv]
// csn_back: executes queued commands, keeps clock, role and timestamps,
// and drives the result register. Depends on csn_pkg.
module csn_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  csn_pkg::cmd_t         head,
  input  csn_pkg::fifo_stat_t   fifo_stat,
  output logic                  pop,
  input  logic [31:0]           node_addr,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csn_pkg::reply_t       out_reply,
  output csn_pkg::back_stat_t   stat
);
  import csn_pkg::*;

  bstate_t            state_r, state_nxt;
  role_t              role_r, role_nxt;
  logic [CLK_W-1:0]   clk_us_r, clk_us_nxt;
  logic [Q_W-1:0]     q_r, q_nxt;
  logic [US_W-1:0]    r_r, r_nxt;
  logic [CLK_W-1:0]   t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt, t4_r, t4_nxt;
  logic [CLK_W-1:0]   wa_r, wa_nxt, wb_r, wb_nxt, base_r, base_nxt;
  logic [CLK_W-1:0]   div_sh_r, div_sh_nxt;
  logic [US_W-1:0]    div_rem_r, div_rem_nxt;
  logic [Q_W-1:0]     div_quo_r, div_quo_nxt;
  logic [DCNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  reply_t             out_r, out_nxt;

  logic               want;
  logic               out_free;
  logic [CLK_W-1:0]   head_time;
  logic [CLK_W-1:0]   new_clk;
  logic [US_W:0]      trial;
  reply_t             rep;

  function automatic logic res_want(kind_t k, role_t ro);
    logic w;
    case (k)
      K_HELLO, K_SET_MASTER, K_SET_SLAVE, K_SET_TIME, K_GET_TIME: w = 1'b1;
      K_SYNC:                    w = (ro == ROLE_SLAVE);
      K_DELAY_REQ, K_SEND_SYNC:  w = (ro == ROLE_MASTER);
      default:                   w = 1'b0;
    endcase
    return w;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    role_nxt      = role_r;
    clk_us_nxt    = clk_us_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    t3_nxt        = t3_r;
    t4_nxt        = t4_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    base_nxt      = base_r;
    div_sh_nxt    = div_sh_r;
    div_rem_nxt   = div_rem_r;
    div_quo_nxt   = div_quo_r;
    div_cnt_nxt   = div_cnt_r;
    new_clk       = clk_us_r - wa_r;
    trial         = '0;
    head_time     = CLK_W'(head.prod) + CLK_W'(head.micros);

    out_free      = !out_valid_r || out_ready;
    want          = res_want(head.kind, role_r);
    pop           = fifo_stat.not_empty && (state_r == BS_EXEC) && (!want || out_free);

    // echo reply by default, time replies override the args
    rep.dst       = head.reply_dst;
    rep.src       = node_addr;
    rep.code      = CODE_ACK;
    rep.arg_count = 2'd1;
    rep.arg0      = 32'(head.opcode);
    rep.arg1      = '0;

    case (state_r)
      BS_EXEC: begin
        case (head.kind)
          K_GET_TIME, K_DELAY_REQ, K_SEND_SYNC: begin
            rep.arg_count = 2'd2;
            rep.arg0      = q_r[31:0];
            rep.arg1      = r_r;
            if (head.kind == K_GET_TIME) begin
              rep.code = CODE_TIME;
            end else if (head.kind == K_DELAY_REQ) begin
              rep.code = CODE_DRE;
            end else begin
              rep.code = CODE_SYN;
              rep.dst  = BCAST_ADDR;
            end
          end
          K_SYNC:  rep.code = CODE_DRQ;
          default: rep.code = CODE_ACK;
        endcase
        if (pop) begin
          case (head.kind)
            K_TICK: begin
              clk_us_nxt = clk_us_r + 1'b1;
              if (clk_us_r == '1) begin
                q_nxt = '0;
                r_nxt = '0;
              end else if (r_r == US_PER_S - 1'b1) begin
                q_nxt = q_r + 1'b1;
                r_nxt = '0;
              end else begin
                r_nxt = r_r + 1'b1;
              end
            end
            K_SET_MASTER: role_nxt = ROLE_MASTER;
            K_SET_SLAVE:  role_nxt = ROLE_SLAVE;
            K_SET_TIME: begin
              if (head.load) begin
                clk_us_nxt = head_time;
                q_nxt      = Q_W'(head.q_in);
                r_nxt      = head.r_in;
              end
            end
            K_SYNC: begin
              if (role_r == ROLE_SLAVE) begin
                t1_nxt = head_time;
                t2_nxt = clk_us_r;
                t3_nxt = clk_us_r;
              end
            end
            K_DELAY_RESP: begin
              if (role_r == ROLE_SLAVE) begin
                t4_nxt    = head_time;
                state_nxt = BS_DIFF;
              end
            end
            default: ;
          endcase
        end
      end
      BS_DIFF: begin
        wa_nxt    = t4_r - t1_r;
        wb_nxt    = t3_r - t2_r;
        base_nxt  = t2_r - t1_r;
        state_nxt = BS_SUM;
      end
      BS_SUM: begin
        wa_nxt    = wa_r - wb_r;
        state_nxt = BS_HALF;
      end
      BS_HALF: begin
        // halving toward zero: bias negatives by one, then arithmetic shift
        wa_nxt    = CLK_W'($signed(wa_r + CLK_W'(wa_r[CLK_W-1])) >>> 1);
        state_nxt = BS_OFFS;
      end
      BS_OFFS: begin
        wa_nxt    = base_r - wa_r;
        state_nxt = BS_APPLY;
      end
      BS_APPLY: begin
        clk_us_nxt  = new_clk;
        div_sh_nxt  = new_clk;
        div_rem_nxt = '0;
        div_quo_nxt = '0;
        div_cnt_nxt = '0;
        state_nxt   = BS_DIV;
      end
      BS_DIV: begin
        for (int i = 0; i < DIV_BITS; i++) begin
          trial      = {div_rem_nxt, div_sh_nxt[CLK_W-1]};
          div_sh_nxt = {div_sh_nxt[CLK_W-2:0], 1'b0};
          if (trial >= (US_W + 1)'(US_PER_S)) begin
            div_rem_nxt = US_W'(trial - (US_W + 1)'(US_PER_S));
            div_quo_nxt = {div_quo_nxt[Q_W-2:0], 1'b1};
          end else begin
            div_rem_nxt = trial[US_W-1:0];
            div_quo_nxt = {div_quo_nxt[Q_W-2:0], 1'b0};
          end
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DCNT_W'(DIV_ITERS - 1)) begin
          q_nxt     = div_quo_nxt;
          r_nxt     = div_rem_nxt;
          state_nxt = BS_EXEC;
        end
      end
      default: state_nxt = BS_EXEC;
    endcase

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (pop && want) begin
      out_valid_nxt = 1'b1;
      out_nxt       = rep;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_EXEC;
      role_r      <= ROLE_UNDEF;
      clk_us_r    <= '0;
      q_r         <= '0;
      r_r         <= '0;
      t1_r        <= '0;
      t2_r        <= '0;
      t3_r        <= '0;
      t4_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      role_r      <= role_nxt;
      clk_us_r    <= clk_us_nxt;
      q_r         <= q_nxt;
      r_r         <= r_nxt;
      t1_r        <= t1_nxt;
      t2_r        <= t2_nxt;
      t3_r        <= t3_nxt;
      t4_r        <= t4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wa_r      <= wa_nxt;
    wb_r      <= wb_nxt;
    base_r    <= base_nxt;
    div_sh_r  <= div_sh_nxt;
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    div_cnt_r <= div_cnt_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_reply = out_r;
  assign stat.busy = (state_r != BS_EXEC);

endmodule

[rtl/core/clock_sync_protocol_node_top.sv]
// clock_sync_protocol_node_top: two-way time sync node, front classifier,
// command queue and execution back end. Depends on csn_pkg, csn_front,
// csn_fifo and csn_back.
//
//  port group   dir  beat contents
//  in_*         in   decoded message or local event (tick, send sync)
//  out_*        out  reply message (ack, delay request/response, time, sync)
//  cfg_*        in   node address
//
// The front takes one beat per cycle while the queue has room; the back
// retires one command per cycle outside a correction, so a steady stream
// runs at one beat a cycle. A result waiting in the output register blocks
// only commands that reply. A slave's delay response runs the 64-bit
// correction chain (BS_DIFF to BS_APPLY) and the clock-to-seconds divider
// (BS_DIV), four quotient bits a step. Reset has no clearing pass.
module clock_sync_protocol_node_top #(
  parameter int QUEUE_DEPTH = csn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // msg_destination, msg_source, arg_count, arg_seconds, arg_micros
  input  logic [csn_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode
  input  logic [csn_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // reply_destination, reply_source, reply_arg_count, reply_arg0, reply_arg1
  output logic [csn_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // reply_code
  output logic [csn_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [31:0]                       cfg_data
);
  import csn_pkg::*;

  in_item_t    in_item;
  cmd_t        push_data;
  cmd_t        head;
  fifo_stat_t  fifo_stat;
  back_stat_t  back_stat;
  reply_t      reply;
  logic        push;
  logic        pop;
  logic [31:0] node_addr;

  assign in_item.opcode    = in_tuser[3:0];
  assign in_item.dst       = in_tdata[31:0];
  assign in_item.src       = in_tdata[63:32];
  assign in_item.arg_count = in_tdata[71:64];
  assign in_item.sec       = in_tdata[103:72];
  assign in_item.micros    = in_tdata[123:104];

  csn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data),
    .node_addr (node_addr)
  );

  csn_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  csn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .node_addr (node_addr),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_reply (reply),
    .stat      (back_stat)
  );

  assign out_tdata = {2'b00, reply.arg1, reply.arg0, reply.arg_count, reply.src, reply.dst};
  assign out_tuser = reply.code;

`ifndef SYNTH
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.full |-> !in_tready)
    else $error("beat taken while command queue full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> fifo_stat.not_empty)
    else $error("command popped from empty queue");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.busy |-> !pop)
    else $error("command popped during clock correction");
`endif

endmodule
